>>> design/rtpf_pkg.sv
// shared constants, register indexes and the divide-by-255 helper for the
// rgb to pixel format packer; no dependencies
package rtpf_pkg;

   localparam int SampleWidth   = 8;
   localparam int MaxWidth      = 16;
   localparam int ProductWidth  = SampleWidth + MaxWidth;
   localparam int ShiftWidth    = 5;
   localparam int PixBitsWidth  = 6;
   localparam int WireWidth     = 32;
   localparam int CountWidth    = 3;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_PIXEL_BITS  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BIG_ENDIAN  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RED_MAX     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_GREEN_MAX   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_BLUE_MAX    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_RED_SHIFT   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_GREEN_SHIFT = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_BLUE_SHIFT  = 3'd7;

   localparam logic [PixBitsWidth-1:0] PIX_8  = 6'd8;
   localparam logic [PixBitsWidth-1:0] PIX_16 = 6'd16;
   localparam logic [PixBitsWidth-1:0] PIX_32 = 6'd32;

   localparam logic [CountWidth-1:0] COUNT_NONE = 3'd0;
   localparam logic [CountWidth-1:0] COUNT_ONE  = 3'd1;
   localparam logic [CountWidth-1:0] COUNT_TWO  = 3'd2;
   localparam logic [CountWidth-1:0] COUNT_FOUR = 3'd4;

   localparam logic [PixBitsWidth-1:0] RST_PIXEL_BITS  = PIX_32;
   localparam logic                    RST_BIG_ENDIAN  = 1'b0;
   localparam logic [MaxWidth-1:0]     RST_MAX         = 16'd255;
   localparam logic [ShiftWidth-1:0]   RST_RED_SHIFT   = 5'd16;
   localparam logic [ShiftWidth-1:0]   RST_GREEN_SHIFT = 5'd8;
   localparam logic [ShiftWidth-1:0]   RST_BLUE_SHIFT  = 5'd0;

   // low byte of floor(x / 255): estimate from x/256 + x/65536, then fix up
   // with the remainder, which stays below four divisors
   function automatic logic [SampleWidth-1:0] div255(input logic [ProductWidth-1:0] x);
      logic [16:0] q0;
      logic [24:0] q0_times;
      logic [24:0] rem_full;
      logic [9:0]  rem;
      logic [1:0]  fix;
      q0       = {1'b0, x[23:8]} + {9'b0, x[23:16]};
      q0_times = {q0, 8'b0} - {8'b0, q0};
      rem_full = {1'b0, x} - q0_times;
      rem      = rem_full[9:0];
      if (rem >= 10'd765) begin
         fix = 2'd3;
      end else if (rem >= 10'd510) begin
         fix = 2'd2;
      end else if (rem >= 10'd255) begin
         fix = 2'd1;
      end else begin
         fix = 2'd0;
      end
      return q0[7:0] + {6'b0, fix};
   endfunction

endpackage

>>> design/rtpf_scale.sv
// one color channel: registered sample * max product, then divide by 255
// uses rtpf_pkg
module rtpf_scale
   import rtpf_pkg::*;
(
   input  logic                    clock,
   input  logic [SampleWidth-1:0]  sample,
   input  logic [MaxWidth-1:0]     max_val,
   output logic [SampleWidth-1:0]  scaled
);

   logic [ProductWidth-1:0] product_ff;
   logic [ProductWidth-1:0] product_in;

   assign product_in = {{MaxWidth{1'b0}}, sample} * {{SampleWidth{1'b0}}, max_val};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign scaled = div255(product_ff);

endmodule

>>> design/rgb_to_pixel_format_packer_core.sv
// top level of the rgb to pixel format packer: csr registers, input stage,
// pixel packing and result register; uses rtpf_pkg and rtpf_scale
//
// One pixel can be started every clock: busy is only a registered copy of reset.
// Each transaction's result appears on the rsp_ ports with rsp_strobe high for
// one cycle, after the input register, the channel multiply register and the
// result register, in start order. The receiver cannot stall. Write csr
// registers only while no pixel is in flight.
module rgb_to_pixel_format_packer_core
   import rtpf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [SampleWidth-1:0]   req_red_in,
   input  logic [SampleWidth-1:0]   req_green_in,
   input  logic [SampleWidth-1:0]   req_blue_in,
   output logic                     rsp_strobe,
   output logic [WireWidth-1:0]     rsp_wire_bytes,
   output logic [CountWidth-1:0]    rsp_byte_count,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   logic                     busy_ff;
   logic [PixBitsWidth-1:0]  pixel_bits_ff;
   logic                     big_endian_ff;
   logic [MaxWidth-1:0]      red_max_ff;
   logic [MaxWidth-1:0]      green_max_ff;
   logic [MaxWidth-1:0]      blue_max_ff;
   logic [ShiftWidth-1:0]    red_shift_ff;
   logic [ShiftWidth-1:0]    green_shift_ff;
   logic [ShiftWidth-1:0]    blue_shift_ff;

   logic                     accept;
   logic                     in_valid_ff;
   logic                     prod_valid_ff;
   logic                     rsp_strobe_ff;
   logic [SampleWidth-1:0]   red_ff;
   logic [SampleWidth-1:0]   green_ff;
   logic [SampleWidth-1:0]   blue_ff;
   logic [SampleWidth-1:0]   red_scaled;
   logic [SampleWidth-1:0]   green_scaled;
   logic [SampleWidth-1:0]   blue_scaled;
   logic [WireWidth-1:0]     word;
   logic [WireWidth-1:0]     wire_in;
   logic [CountWidth-1:0]    count_in;
   logic [WireWidth-1:0]     wire_ff;
   logic [CountWidth-1:0]    count_ff;

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;
   assign accept    = start & ~busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bits_ff  <= RST_PIXEL_BITS;
         big_endian_ff  <= RST_BIG_ENDIAN;
         red_max_ff     <= RST_MAX;
         green_max_ff   <= RST_MAX;
         blue_max_ff    <= RST_MAX;
         red_shift_ff   <= RST_RED_SHIFT;
         green_shift_ff <= RST_GREEN_SHIFT;
         blue_shift_ff  <= RST_BLUE_SHIFT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_BITS:  pixel_bits_ff  <= csr_wdata[PixBitsWidth-1:0];
            CSR_BIG_ENDIAN:  big_endian_ff  <= csr_wdata[0];
            CSR_RED_MAX:     red_max_ff     <= csr_wdata;
            CSR_GREEN_MAX:   green_max_ff   <= csr_wdata;
            CSR_BLUE_MAX:    blue_max_ff    <= csr_wdata;
            CSR_RED_SHIFT:   red_shift_ff   <= csr_wdata[ShiftWidth-1:0];
            CSR_GREEN_SHIFT: green_shift_ff <= csr_wdata[ShiftWidth-1:0];
            CSR_BLUE_SHIFT:  blue_shift_ff  <= csr_wdata[ShiftWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         in_valid_ff   <= accept;
         prod_valid_ff <= in_valid_ff;
         rsp_strobe_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
   end

   rtpf_scale u_red (
      .clock   (clock),
      .sample  (red_ff),
      .max_val (red_max_ff),
      .scaled  (red_scaled)
   );

   rtpf_scale u_green (
      .clock   (clock),
      .sample  (green_ff),
      .max_val (green_max_ff),
      .scaled  (green_scaled)
   );

   rtpf_scale u_blue (
      .clock   (clock),
      .sample  (blue_ff),
      .max_val (blue_max_ff),
      .scaled  (blue_scaled)
   );

   assign word = ({{(WireWidth-SampleWidth){1'b0}}, red_scaled} << red_shift_ff)
               | ({{(WireWidth-SampleWidth){1'b0}}, green_scaled} << green_shift_ff)
               | ({{(WireWidth-SampleWidth){1'b0}}, blue_scaled} << blue_shift_ff);

   always_comb begin
      case (pixel_bits_ff)
         PIX_32: begin
            wire_in  = big_endian_ff ? {word[7:0], word[15:8], word[23:16], word[31:24]}
                                     : word;
            count_in = COUNT_FOUR;
         end
         PIX_16: begin
            wire_in  = big_endian_ff ? {16'b0, word[7:0], word[15:8]}
                                     : {16'b0, word[15:0]};
            count_in = COUNT_TWO;
         end
         PIX_8: begin
            wire_in  = {24'b0, word[7:0]};
            count_in = COUNT_ONE;
         end
         default: begin
            wire_in  = '0;
            count_in = COUNT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (prod_valid_ff) begin
         wire_ff  <= wire_in;
         count_ff <= count_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_wire_bytes = wire_ff;
   assign rsp_byte_count = count_ff;

`ifndef SYNTH
   a_strobe_from_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(prod_valid_ff))
      else $error("result strobe without a transaction in the multiply stage");

   a_pipe_from_input: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> $past(in_valid_ff))
      else $error("multiply stage valid without a captured transaction");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_byte_count == COUNT_NONE || rsp_byte_count == COUNT_ONE ||
                      rsp_byte_count == COUNT_TWO || rsp_byte_count == COUNT_FOUR))
      else $error("illegal byte count on result");

   a_unused_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_byte_count == COUNT_ONE) |-> rsp_wire_bytes[31:8] == 24'b0)
      else $error("bytes beyond a one-byte pixel are not zero");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_byte_count == COUNT_NONE) |-> rsp_wire_bytes == '0)
      else $error("unsupported pixel size gave nonzero bytes");
`endif

endmodule
